// ===== sv/priority_message_queue_macros.svh =====
// Assertion macros for the priority message queue checker.
`ifndef PRIORITY_MESSAGE_QUEUE_MACROS_SVH
`define PRIORITY_MESSAGE_QUEUE_MACROS_SVH

// same-cycle implication
`define PMQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pmq_pkg.sv =====
// Package: types, constants and field layout of the priority message queue.
`default_nettype none
package pmq_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int MSG_WORDS_DEF   = 8;
    localparam int PRIO_LEVELS_DEF = 32;
    localparam int WORD_BYTES      = 8;

    localparam int REQ_W      = 2;
    localparam int PRIO_F_W   = 5;
    localparam int DATA_W     = 64;
    localparam int LEN_W      = 7;
    localparam int STATUS_W   = 3;
    localparam int CNT_F_W    = 5;
    localparam int MAXMSG_W   = 7;
    localparam int CAP_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [MAXMSG_W-1:0] RESET_MAX_MSG = 7'd64;
    localparam logic [CAP_W-1:0]    RESET_CAP     = 5'd16;

    // input tdata layout
    localparam int IN_PRIO_LSB = 0;
    localparam int IN_DATA_LSB = IN_PRIO_LSB + PRIO_F_W;
    localparam int IN_LEN_LSB  = IN_DATA_LSB + DATA_W;
    localparam int IN_USED_W   = IN_LEN_LSB + LEN_W;
    localparam int S_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_WORD_LSB   = 0;
    localparam int OUT_PRIO_LSB   = OUT_WORD_LSB + DATA_W;
    localparam int OUT_LEN_LSB    = OUT_PRIO_LSB + PRIO_F_W;
    localparam int OUT_CNT_LSB    = OUT_LEN_LSB + LEN_W;
    localparam int OUT_NOTIFY_BIT = OUT_CNT_LSB + CNT_F_W;
    localparam int OUT_USED_W     = OUT_NOTIFY_BIT + 1;
    localparam int M_TDATA_W      = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_SEND   = 2'd0,
        REQ_RECV   = 2'd1,
        REQ_ARM    = 2'd2,
        REQ_DISARM = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_TOO_BIG   = 3'd3,
        STAT_BUF_SMALL = 3'd4,
        STAT_NOT_ARMED = 3'd5
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_RD,
        ST_WORD
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic copy_step;
        logic rd_issue;
        logic word_load;
    } pmq_cmd_t;

    typedef struct packed {
        logic is_send;
        logic is_recv;
        logic last;
        logic send_ok;
        logic recv_ok;
        logic copy_done;
        logic word_last;
        logic out_busy;
    } pmq_sts_t;

endpackage
`default_nettype wire

// ===== sv/pmq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pmq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/pmq_ctrl.sv =====
// Controller: sequences capture, execution, payload copy and word readout.
`default_nettype none
module pmq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire pmq_pkg::pmq_sts_t sts,
    output pmq_pkg::pmq_cmd_t      cmd
);
    import pmq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !sts.out_busy)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.is_send && sts.last && sts.send_ok)
                begin
                    state_next = ST_COPY;
                end
                else if (sts.is_recv && sts.recv_ok)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                if (sts.copy_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_WORD;
            end
            ST_WORD:
            begin
                if (!sts.out_busy)
                begin
                    state_next = sts.word_last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = !sts.out_busy;
                cmd.capture = s_tvalid && !sts.out_busy;
            end
            ST_EXEC:  cmd.exec = 1'b1;
            ST_COPY:  cmd.copy_step = 1'b1;
            ST_RD:    cmd.rd_issue = 1'b1;
            ST_WORD:  cmd.word_load = !sts.out_busy;
            default:  cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/pmq_datapath.sv =====
// Datapath: slot lists, level mask, staging and payload memories, result register.
`default_nettype none
module pmq_datapath #(
    parameter int SLOTS       = pmq_pkg::SLOTS_DEF,
    parameter int MSG_WORDS   = pmq_pkg::MSG_WORDS_DEF,
    parameter int PRIO_LEVELS = pmq_pkg::PRIO_LEVELS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pmq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pmq_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [pmq_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [pmq_pkg::REQ_W-1:0]        s_tuser,
    input  wire logic                             s_tlast,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output logic      [pmq_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic      [pmq_pkg::STATUS_W-1:0]     m_tuser,
    output logic                                  m_tlast,
    input  wire pmq_pkg::pmq_cmd_t                cmd,
    output pmq_pkg::pmq_sts_t                     sts
);
    import pmq_pkg::*;

    localparam int SLOT_W    = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int WIDX_W    = $clog2(MSG_WORDS + 1);
    localparam int WA_W      = MSG_WORDS > 1 ? $clog2(MSG_WORDS) : 1;
    localparam int LVL_W     = $clog2(PRIO_LEVELS);
    localparam int HCNT_W    = $clog2(SLOTS + 1);
    localparam int CAPC_W    = HCNT_W > CAP_W ? HCNT_W : CAP_W;
    localparam int PAY_DEPTH = SLOTS * MSG_WORDS;
    localparam int PAY_AW    = PAY_DEPTH > 1 ? $clog2(PAY_DEPTH) : 1;
    localparam int MSG_BYTES = MSG_WORDS * WORD_BYTES;
    localparam int LIM_W     = $clog2(MSG_BYTES + 1);
    localparam int CMP_W     = (LIM_W > LEN_W ? LIM_W : LEN_W) + 1;
    localparam int PSAT_W    = PRIO_F_W + 1;

    // configuration and queue state
    logic [MAXMSG_W-1:0] max_msg_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [SLOT_W-1:0]   slot_next_reg [SLOTS];
    logic [LEN_W-1:0]    slot_len_reg  [SLOTS];
    logic [SLOT_W-1:0]   level_head_reg [PRIO_LEVELS];
    logic [SLOT_W-1:0]   level_tail_reg [PRIO_LEVELS];
    logic [PRIO_LEVELS-1:0] level_mask_reg;
    logic [LVL_W-1:0]    top_reg;
    logic [SLOT_W-1:0]   free_head_reg;
    logic [HCNT_W-1:0]   held_reg;
    logic                armed_reg;
    logic [WIDX_W-1:0]   widx_reg;
    logic                serr_reg;

    // captured request
    req_t                rq_type_reg;
    logic [PRIO_F_W-1:0] rq_prio_reg;
    logic [DATA_W-1:0]   rq_word_reg;
    logic [LEN_W-1:0]    rq_len_reg;
    logic                rq_last_reg;

    // per-message work registers
    logic [SLOT_W-1:0]   slot_reg;
    logic [LVL_W-1:0]    lvl_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [WIDX_W-1:0]   nw_reg;
    logic [WIDX_W-1:0]   copy_cnt_reg;
    logic [WIDX_W-1:0]   c_reg;
    logic [WIDX_W-1:0]   k_reg;
    logic                fired_reg;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [DATA_W-1:0]   out_word_reg;
    logic [PRIO_F_W-1:0] out_prio_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_last_reg;
    logic [CNT_F_W-1:0]  out_cnt_reg;
    logic                out_notify_reg;

    // combinational
    logic [CAPC_W-1:0]   cap_ext;
    logic [CAPC_W-1:0]   cap_now;
    logic [CAPC_W-1:0]   cfg_cap_ext;
    logic [CAPC_W-1:0]   cfg_cap_now;
    logic [CMP_W-1:0]    lim_ext;
    logic [CMP_W-1:0]    limit;
    logic                too_big;
    logic                full;
    logic                send_ok;
    logic                buf_small;
    logic                recv_ok;
    logic [LVL_W-1:0]    prio_sat;
    logic [LVL_W-1:0]    lt_raddr;
    logic [SLOT_W-1:0]   lt_rdata;
    logic [SLOT_W-1:0]   head_top;
    logic [SLOT_W-1:0]   sn_raddr;
    logic [SLOT_W-1:0]   sn_rdata;
    logic [PRIO_LEVELS-1:0] mask_clr;
    logic [LVL_W-1:0]    top_new;
    logic [LEN_W-1:0]    pop_len;
    logic [LEN_W:0]      nw_raw;
    logic [WIDX_W-1:0]   nw_calc;
    logic                fired;
    logic                emit_exec;
    status_t             exec_status;
    logic                exec_is_send;
    logic                exec_is_recv;

    logic                stage_we;
    logic [DATA_W-1:0]   stage_rdata;
    logic                pay_we;
    logic [PAY_AW-1:0]   pay_waddr;
    logic [PAY_AW-1:0]   pay_raddr;
    logic [DATA_W-1:0]   pay_rdata;
    logic [CMP_W-1:0]    used;
    logic [CMP_W-1:0]    rem;
    logic [DATA_W-1:0]   word_masked;
    logic                word_last;
    logic                load_out;

    function automatic logic [SLOT_W-1:0] chain_next(input int i, input logic [CAPC_W-1:0] cap);
        logic [CAPC_W:0] nx;
        nx = (CAPC_W + 1)'(i + 1);
        return (nx < {1'b0, cap}) ? SLOT_W'(i + 1) : '0;
    endfunction

    assign exec_is_send = (rq_type_reg == REQ_SEND);
    assign exec_is_recv = (rq_type_reg == REQ_RECV);

    assign cap_ext     = CAPC_W'(cap_reg);
    assign cap_now     = (cap_ext > CAPC_W'(SLOTS)) ? CAPC_W'(SLOTS) : cap_ext;
    assign cfg_cap_ext = CAPC_W'(cfg_data[CAP_W-1:0]);
    assign cfg_cap_now = (cfg_cap_ext > CAPC_W'(SLOTS)) ? CAPC_W'(SLOTS) : cfg_cap_ext;

    assign lim_ext  = CMP_W'(max_msg_reg);
    assign limit    = (lim_ext > CMP_W'(MSG_BYTES)) ? CMP_W'(MSG_BYTES) : lim_ext;
    assign too_big  = serr_reg || (widx_reg >= WIDX_W'(MSG_WORDS))
                      || (CMP_W'(rq_len_reg) > limit);
    assign full     = (CAPC_W'(held_reg) >= cap_now);
    assign send_ok  = !too_big && !full;

    assign buf_small = (rq_len_reg < max_msg_reg);
    assign recv_ok   = !buf_small && (held_reg != '0);

    assign prio_sat = ({1'b0, rq_prio_reg} >= PSAT_W'(PRIO_LEVELS))
                      ? LVL_W'(PRIO_LEVELS - 1) : LVL_W'(rq_prio_reg);

    assign lt_raddr = exec_is_send ? prio_sat : top_reg;
    assign lt_rdata = level_tail_reg[lt_raddr];
    assign head_top = level_head_reg[top_reg];
    assign sn_raddr = exec_is_send ? free_head_reg : head_top;
    assign sn_rdata = slot_next_reg[sn_raddr];
    assign pop_len  = slot_len_reg[head_top];

    assign mask_clr = level_mask_reg & ~(PRIO_LEVELS'(1) << top_reg);

    always_comb
    begin
        top_new = '0;
        for (int p = 0; p < PRIO_LEVELS; p++)
        begin
            if (mask_clr[p])
            begin
                top_new = LVL_W'(p);
            end
        end
    end

    assign nw_raw  = ({1'b0, pop_len} + (LEN_W + 1)'(WORD_BYTES - 1)) >> 3;
    always_comb
    begin
        if (nw_raw == '0)
        begin
            nw_calc = WIDX_W'(1);
        end
        else if ((LEN_W + 1 > WIDX_W ? nw_raw : (LEN_W + 1)'(nw_raw))
                 > (LEN_W + 1)'(MSG_WORDS))
        begin
            nw_calc = WIDX_W'(MSG_WORDS);
        end
        else
        begin
            nw_calc = WIDX_W'(nw_raw);
        end
    end

    assign fired = armed_reg && (held_reg == '0);

    always_comb
    begin
        exec_status = STAT_OK;
        emit_exec   = 1'b0;
        case (rq_type_reg)
            REQ_SEND:
            begin
                exec_status = too_big ? STAT_TOO_BIG : STAT_FULL;
                emit_exec   = rq_last_reg && !send_ok;
            end
            REQ_RECV:
            begin
                exec_status = buf_small ? STAT_BUF_SMALL : STAT_EMPTY;
                emit_exec   = !recv_ok;
            end
            REQ_ARM:
            begin
                exec_status = STAT_OK;
                emit_exec   = 1'b1;
            end
            default:
            begin
                exec_status = armed_reg ? STAT_OK : STAT_NOT_ARMED;
                emit_exec   = 1'b1;
            end
        endcase
        emit_exec = emit_exec && cmd.exec;
    end

    // staging and payload memories
    assign stage_we  = cmd.exec && exec_is_send && (widx_reg < WIDX_W'(MSG_WORDS));
    assign pay_we    = cmd.copy_step && (c_reg != '0);
    assign pay_waddr = PAY_AW'(slot_reg) * PAY_AW'(MSG_WORDS) + PAY_AW'(c_reg - WIDX_W'(1));
    assign pay_raddr = PAY_AW'(slot_reg) * PAY_AW'(MSG_WORDS) + PAY_AW'(k_reg);

    pmq_ram #(.WIDTH(DATA_W), .DEPTH(MSG_WORDS)) u_stage (
        .clk   (clk),
        .we    (stage_we),
        .waddr (widx_reg[WA_W-1:0]),
        .wdata (rq_word_reg),
        .re    (cmd.copy_step),
        .raddr (c_reg[WA_W-1:0]),
        .rdata (stage_rdata)
    );

    pmq_ram #(.WIDTH(DATA_W), .DEPTH(PAY_DEPTH)) u_payload (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (stage_rdata),
        .re    (cmd.rd_issue),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    // bytes at or beyond the message length read as zero
    assign used = CMP_W'(k_reg) << 3;
    assign rem  = (CMP_W'(len_reg) > used) ? CMP_W'(len_reg) - used : '0;
    always_comb
    begin
        for (int b = 0; b < WORD_BYTES; b++)
        begin
            word_masked[8*b +: 8] = (CMP_W'(b) < rem) ? pay_rdata[8*b +: 8] : 8'd0;
        end
    end
    assign word_last = ((k_reg + WIDX_W'(1)) == nw_reg);

    assign load_out = emit_exec || (cmd.copy_step && sts.copy_done) || cmd.word_load;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_msg_reg    <= RESET_MAX_MSG;
            cap_reg        <= RESET_CAP;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_next_reg[i] <= chain_next(i, (CAPC_W'(RESET_CAP) > CAPC_W'(SLOTS))
                                                  ? CAPC_W'(SLOTS) : CAPC_W'(RESET_CAP));
            end
            level_mask_reg <= '0;
            top_reg        <= '0;
            free_head_reg  <= '0;
            held_reg       <= '0;
            armed_reg      <= 1'b0;
            widx_reg       <= '0;
            serr_reg       <= 1'b0;
            c_reg          <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end

            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_MSG)
                begin
                    max_msg_reg <= cfg_data;
                end
                else
                begin
                    cap_reg <= cfg_data[CAP_W-1:0];
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        slot_next_reg[i] <= chain_next(i, cfg_cap_now);
                    end
                    level_mask_reg <= '0;
                    top_reg        <= '0;
                    free_head_reg  <= '0;
                    held_reg       <= '0;
                    widx_reg       <= '0;
                    serr_reg       <= 1'b0;
                end
            end

            if (cmd.exec)
            begin
                c_reg <= '0;
                k_reg <= '0;
                case (rq_type_reg)
                    REQ_SEND:
                    begin
                        if (!rq_last_reg)
                        begin
                            if (widx_reg < WIDX_W'(MSG_WORDS))
                            begin
                                widx_reg <= widx_reg + WIDX_W'(1);
                            end
                            else
                            begin
                                serr_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            widx_reg <= '0;
                            serr_reg <= 1'b0;
                            if (send_ok)
                            begin
                                free_head_reg                <= sn_rdata;
                                slot_next_reg[free_head_reg] <= '0;
                                if (level_mask_reg[prio_sat])
                                begin
                                    slot_next_reg[lt_rdata] <= free_head_reg;
                                end
                                else
                                begin
                                    level_mask_reg[prio_sat] <= 1'b1;
                                    if (prio_sat > top_reg)
                                    begin
                                        top_reg <= prio_sat;
                                    end
                                end
                                held_reg <= held_reg + HCNT_W'(1);
                                if (fired)
                                begin
                                    armed_reg <= 1'b0;
                                end
                            end
                        end
                    end
                    REQ_RECV:
                    begin
                        if (recv_ok)
                        begin
                            if (head_top == lt_rdata)
                            begin
                                level_mask_reg <= mask_clr;
                                top_reg        <= top_new;
                            end
                            slot_next_reg[head_top] <= free_head_reg;
                            free_head_reg           <= head_top;
                            held_reg                <= held_reg - HCNT_W'(1);
                        end
                    end
                    REQ_ARM:
                    begin
                        armed_reg <= 1'b1;
                    end
                    default:
                    begin
                        armed_reg <= 1'b0;
                    end
                endcase
            end

            if (cmd.copy_step)
            begin
                c_reg <= c_reg + WIDX_W'(1);
            end
            if (cmd.word_load)
            begin
                k_reg <= k_reg + WIDX_W'(1);
            end
        end
    end

    // payload and list contents
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rq_type_reg <= req_t'(s_tuser);
            rq_prio_reg <= s_tdata[IN_PRIO_LSB +: PRIO_F_W];
            rq_word_reg <= s_tdata[IN_DATA_LSB +: DATA_W];
            rq_len_reg  <= s_tdata[IN_LEN_LSB +: LEN_W];
            rq_last_reg <= s_tlast;
        end

        if (cmd.exec && exec_is_send && rq_last_reg && send_ok)
        begin
            slot_len_reg[free_head_reg] <= rq_len_reg;
            if (level_mask_reg[prio_sat])
            begin
                level_tail_reg[prio_sat] <= free_head_reg;
            end
            else
            begin
                level_head_reg[prio_sat] <= free_head_reg;
                level_tail_reg[prio_sat] <= free_head_reg;
            end
            slot_reg     <= free_head_reg;
            copy_cnt_reg <= widx_reg + WIDX_W'(1);
            fired_reg    <= fired;
        end

        if (cmd.exec && exec_is_recv && recv_ok)
        begin
            if (head_top != lt_rdata)
            begin
                level_head_reg[top_reg] <= sn_rdata;
            end
            slot_reg <= head_top;
            lvl_reg  <= top_reg;
            len_reg  <= pop_len;
            nw_reg   <= nw_calc;
        end

        if (emit_exec)
        begin
            out_status_reg <= exec_status;
            out_word_reg   <= '0;
            out_prio_reg   <= '0;
            out_len_reg    <= '0;
            out_last_reg   <= 1'b1;
            out_cnt_reg    <= CNT_F_W'(held_reg);
            out_notify_reg <= 1'b0;
        end
        else if (cmd.copy_step && sts.copy_done)
        begin
            out_status_reg <= STAT_OK;
            out_word_reg   <= '0;
            out_prio_reg   <= '0;
            out_len_reg    <= '0;
            out_last_reg   <= 1'b1;
            out_cnt_reg    <= CNT_F_W'(held_reg);
            out_notify_reg <= fired_reg;
        end
        else if (cmd.word_load)
        begin
            out_status_reg <= STAT_OK;
            out_word_reg   <= word_masked;
            out_prio_reg   <= PRIO_F_W'(lvl_reg);
            out_len_reg    <= len_reg;
            out_last_reg   <= word_last;
            out_cnt_reg    <= CNT_F_W'(held_reg);
            out_notify_reg <= 1'b0;
        end
    end

    assign sts.is_send   = exec_is_send;
    assign sts.is_recv   = exec_is_recv;
    assign sts.last      = rq_last_reg;
    assign sts.send_ok   = send_ok;
    assign sts.recv_ok   = recv_ok;
    assign sts.copy_done = (c_reg == copy_cnt_reg);
    assign sts.word_last = word_last;
    assign sts.out_busy  = out_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(M_TDATA_W - OUT_USED_W)'(0), out_notify_reg, out_cnt_reg,
                       out_len_reg, out_prio_reg, out_word_reg};
endmodule
`default_nettype wire

// ===== sv/priority_message_queue.sv =====
// Top level: priority message queue with shared slot pool and per-level lists.
//
//  channel | dir | accept          | contents
//  s_*     | in  | tvalid & tready | requests: send words, receive, arm, disarm
//  m_*     | out | tvalid & tready | results: status, received words
//  cfg_*   | in  | cfg_we          | max_msg_bytes, queue_capacity
//
// A send word is captured, then executed; the last one also copies the staged
// words into the payload RAM. A receive reads each word from the payload RAM
// into the result register. Reset gives an empty queue with a full free chain;
// no clearing pass. A stalled m_* holds the next request off.
`default_nettype none
module priority_message_queue #(
    parameter int SLOTS       = pmq_pkg::SLOTS_DEF,
    parameter int MSG_WORDS   = pmq_pkg::MSG_WORDS_DEF,
    parameter int PRIO_LEVELS = pmq_pkg::PRIO_LEVELS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [pmq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pmq_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // priority_req, data_word, byte_len, zero pad
    input  wire logic [pmq_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  wire logic [pmq_pkg::REQ_W-1:0]      s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // out_word, out_priority, out_len, msg_count, notify, zero pad
    output logic      [pmq_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic      [pmq_pkg::STATUS_W-1:0]   m_tuser,
    output logic                                m_tlast
);
    import pmq_pkg::*;

    pmq_cmd_t cmd;
    pmq_sts_t sts;

    pmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pmq_datapath #(
        .SLOTS       (SLOTS),
        .MSG_WORDS   (MSG_WORDS),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule
`default_nettype wire

// ===== sv/pmq_checker.sv =====
// Port-level checker for the priority message queue, bound to the top level.
`default_nettype none
`include "priority_message_queue_macros.svh"
module pmq_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [pmq_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [pmq_pkg::STATUS_W-1:0]  m_tuser,
    input  wire logic                          m_tlast
);
    import pmq_pkg::*;

    `PMQ_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `PMQ_ASSERT_SAME(a_fail_last, clk, rst_n, m_tvalid && m_tuser != STAT_OK, m_tlast, "failed request gave more than one result")
    `PMQ_ASSERT_SAME(a_notify, clk, rst_n, m_tvalid && m_tdata[OUT_NOTIFY_BIT], m_tuser == STAT_OK && m_tlast && m_tdata[OUT_LEN_LSB +: LEN_W] == '0, "notify on a result that is not a send")
    `PMQ_ASSERT_SAME(a_word_ok, clk, rst_n, m_tvalid && !m_tlast, m_tuser == STAT_OK && !m_tdata[OUT_NOTIFY_BIT], "non-final result that is not a received word")
endmodule

bind priority_message_queue pmq_checker u_pmq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== test/priority_message_queue_tb.sv =====
// Testbench for priority_message_queue: random requests checked against a local model.
`default_nettype none
module priority_message_queue_tb;
    import pmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS = 16;
    localparam int N_WORDS = 8;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE = 40;

    typedef struct {
        req_t        rt;
        logic [4:0]  prio;
        logic [63:0] data;
        logic [6:0]  len;
        logic        last;
    } mq_request_s;

    typedef struct {
        status_t     status;
        logic [63:0] word;
        logic [4:0]  prio;
        logic [6:0]  len;
        logic        last;
        logic [4:0]  count;
        logic        notify;
    } mq_result_s;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic m_tlast;

    priority_message_queue u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mq_request_s pending_requests[$];
    mq_result_s  expected_results[$];
    int errors = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_settings = 0;
    int tx_gap_max = 0;
    int rx_stall_max = 0;
    int rx_hold = 0;

    // queue model state
    logic [63:0] payload[N_SLOTS*N_WORDS];
    bit          payload_ok[N_SLOTS*N_WORDS];
    logic [63:0] staged[N_WORDS];
    int slot_link[N_SLOTS];
    int slot_bytes[N_SLOTS];
    int lvl_first[32];
    int lvl_last[32];
    logic [31:0] lvl_busy;
    int top_lvl, free_first, held, armed, stage_idx, stage_err;
    int max_bytes, cap_reg;

    function automatic int slots_in_use();
        return (cap_reg > N_SLOTS) ? N_SLOTS : cap_reg;
    endfunction

    function automatic void clear_queue();
        int cap;
        cap = slots_in_use();
        for (int i = 0; i < N_SLOTS; i++)
            slot_link[i] = (i + 1 < cap) ? i + 1 : 0;
        free_first = 0;
        held = 0;
        lvl_busy = '0;
        top_lvl = 0;
        stage_idx = 0;
        stage_err = 0;
    endfunction

    function automatic void add_result(status_t st, logic [63:0] w, int p, int l,
                                       bit last, bit fired);
        mq_result_s r;
        r.status = st;
        r.word = w;
        r.prio = p[4:0];
        r.len = l[6:0];
        r.last = last;
        r.count = held[4:0];
        r.notify = fired;
        expected_results.push_back(r);
    endfunction

    function automatic int byte_limit();
        return (max_bytes > 8 * N_WORDS) ? 8 * N_WORDS : max_bytes;
    endfunction

    function automatic void predict_send(mq_request_s q);
        int slot, lim, p;
        bit fired;
        status_t st;
        fired = 0;
        if (stage_idx < N_WORDS)
        begin
            staged[stage_idx] = q.data;
            stage_idx++;
        end
        else
            stage_err = 1;
        if (!q.last)
            return;
        p = q.prio;
        lim = byte_limit();
        if (stage_err != 0 || int'(q.len) > lim)
            st = STAT_TOO_BIG;
        else if (held >= slots_in_use())
            st = STAT_FULL;
        else
        begin
            st = STAT_OK;
            slot = free_first;
            free_first = slot_link[slot];
            for (int i = 0; i < stage_idx; i++)
            begin
                payload[slot*N_WORDS+i] = staged[i];
                payload_ok[slot*N_WORDS+i] = 1;
            end
            slot_bytes[slot] = q.len;
            slot_link[slot] = 0;
            fired = (armed != 0 && held == 0);
            if (lvl_busy[p])
            begin
                slot_link[lvl_last[p]] = slot;
                lvl_last[p] = slot;
            end
            else
            begin
                lvl_first[p] = slot;
                lvl_last[p] = slot;
                lvl_busy[p] = 1'b1;
                if (p > top_lvl)
                    top_lvl = p;
            end
            held++;
            if (fired)
                armed = 0;
        end
        stage_idx = 0;
        stage_err = 0;
        add_result(st, '0, 0, 0, 1, fired);
    endfunction

    function automatic void predict_receive(mq_request_s q);
        int lvl, slot, len, n, rem, p;
        logic [63:0] w;
        if (int'(q.len) < max_bytes)
        begin
            add_result(STAT_BUF_SMALL, '0, 0, 0, 1, 0);
            return;
        end
        if (held == 0)
        begin
            add_result(STAT_EMPTY, '0, 0, 0, 1, 0);
            return;
        end
        lvl = top_lvl;
        slot = lvl_first[lvl];
        len = slot_bytes[slot];
        if (slot == lvl_last[lvl])
        begin
            lvl_busy[lvl] = 1'b0;
            p = lvl;
            while (p > 0 && !lvl_busy[p])
                p--;
            top_lvl = p;
        end
        else
            lvl_first[lvl] = slot_link[slot];
        slot_link[slot] = free_first;
        free_first = slot;
        held--;
        n = (len + 7) / 8;
        if (n == 0)
            n = 1;
        for (int k = 0; k < n; k++)
        begin
            w = payload[slot*N_WORDS+k];
            rem = (len > 8 * k) ? len - 8 * k : 0;
            if (rem == 0)
                w = '0;
            else if (rem < 8)
                w &= {64{1'b1}} >> (64 - 8 * rem);
            add_result(STAT_OK, w, lvl, len, k + 1 == n, 0);
        end
    endfunction

    function automatic void push_request(req_t rt, int prio, logic [63:0] data, int len,
                                         bit last);
        mq_request_s q;
        q.rt = rt;
        q.prio = prio[4:0];
        q.data = data;
        q.len = len[6:0];
        q.last = last;
        pending_requests.push_back(q);
        n_requests++;
        case (rt)
            REQ_SEND: predict_send(q);
            REQ_RECV: predict_receive(q);
            REQ_ARM:
            begin
                armed = 1;
                add_result(STAT_OK, '0, 0, 0, 1, 0);
            end
            default:
            begin
                if (armed != 0)
                begin
                    armed = 0;
                    add_result(STAT_OK, '0, 0, 0, 1, 0);
                end
                else
                    add_result(STAT_NOT_ARMED, '0, 0, 0, 1, 0);
            end
        endcase
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_receive(int buf_len);
        push_request(REQ_RECV, $urandom_range(0, 31), rand_word(), buf_len, $urandom_range(0, 1));
    endfunction

    function automatic int good_buffer();
        return (max_bytes > 127) ? 127 : $urandom_range(max_bytes, 127);
    endfunction

    // A message of nwords words; on the last word the length is trimmed so that a
    // stored message never reads a payload word that was never written.
    function automatic void push_message(int nwords, int len, int prio, bit mix);
        int given, slot, need;
        bit stores;
        for (int i = 0; i < nwords; i++)
        begin
            if (i + 1 == nwords)
            begin
                given = (stage_idx + 1 > N_WORDS) ? N_WORDS : stage_idx + 1;
                stores = stage_idx < N_WORDS && stage_err == 0 && len <= byte_limit()
                         && held < slots_in_use();
                if (stores)
                begin
                    slot = free_first;
                    need = (len + 7) / 8;
                    for (int k = given; k < need; k++)
                        if (!payload_ok[slot*N_WORDS+k])
                        begin
                            len = 8 * k;
                            break;
                        end
                end
            end
            push_request(REQ_SEND, prio, rand_word(), (i + 1 == nwords) ? len : $urandom_range(0, 127),
                         i + 1 == nwords);
            if (mix && i + 1 < nwords && $urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1))
                    push_receive(good_buffer());
                else
                    push_request(req_t'($urandom_range(2, 3)), 0, rand_word(), 0, 0);
            end
        end
    endfunction

    function automatic void push_random();
        int sel, nw;
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            nw = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
            push_message(nw, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                         : $urandom_range(0, byte_limit()), $urandom_range(0, 31), 1);
        end
        else if (sel < 82)
            push_receive(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : good_buffer());
        else
            push_request(req_t'($urandom_range(2, 3)), $urandom_range(0, 31), rand_word(),
                         $urandom_range(0, 127), $urandom_range(0, 1));
    endfunction

    task automatic drain();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_MSG)
            max_bytes = value & 8'h7f;
        else
        begin
            cap_reg = value & 5'h1f;
            clear_queue();
        end
        n_settings++;
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch in result %0d: %s got %0d expected %0d", n_results, what, got, want);
        errors++;
    endtask

    // request driver
    int gap_left = 0;
    always @(posedge clk)
    begin
        mq_request_s q;
        logic [S_TDATA_W-1:0] d;
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (gap_left > 0 || pending_requests.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                q = pending_requests.pop_front();
                d = '0;
                d[IN_PRIO_LSB +: PRIO_F_W] = q.prio;
                d[IN_DATA_LSB +: DATA_W] = q.data;
                d[IN_LEN_LSB +: LEN_W] = q.len;
                s_tvalid <= 1'b1;
                s_tuser <= q.rt;
                s_tlast <= q.last;
                s_tdata <= d;
                gap_left <= $urandom_range(0, tx_gap_max);
            end
        end
    end

    // result monitor
    int stall_left = 0;
    always @(posedge clk)
    begin
        mq_result_s e;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (expected_results.size() == 0)
                report("unexpected result, status", m_tuser, 0);
            else
            begin
                e = expected_results.pop_front();
                if (m_tuser != e.status) report("status", m_tuser, e.status);
                if (m_tdata[OUT_WORD_LSB +: DATA_W] != e.word)
                    report("out_word low half", m_tdata[OUT_WORD_LSB +: 32], e.word[31:0]);
                if (m_tdata[OUT_PRIO_LSB +: PRIO_F_W] != e.prio)
                    report("out_priority", m_tdata[OUT_PRIO_LSB +: PRIO_F_W], e.prio);
                if (m_tdata[OUT_LEN_LSB +: LEN_W] != e.len)
                    report("out_len", m_tdata[OUT_LEN_LSB +: LEN_W], e.len);
                if (m_tlast != e.last) report("last_result", m_tlast, e.last);
                if (m_tdata[OUT_CNT_LSB +: CNT_F_W] != e.count)
                    report("msg_count", m_tdata[OUT_CNT_LSB +: CNT_F_W], e.count);
                if (m_tdata[OUT_NOTIFY_BIT] != e.notify)
                    report("notify", m_tdata[OUT_NOTIFY_BIT], e.notify);
            end
        end
        if (rst_n)
        begin
            if (rx_hold > 0)
            begin
                rx_hold <= rx_hold - 1;
                m_tready <= 1'b0;
            end
            else if (m_tvalid && m_tready)
            begin
                stall_left <= $urandom_range(0, rx_stall_max);
                m_tready <= (rx_stall_max == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // stall watchdog
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_requests.size() == 0 && !s_tvalid && expected_results.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no progress for %0d cycles, %0d results outstanding", STALL_LIMIT,
                     expected_results.size());
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    int settings_max[6] = '{1, 127, 0, 8, 40, 64};
    int settings_cap[6] = '{1, 31, 0, 3, 16, 16};

    initial
    begin
        max_bytes = 64;
        cap_reg = 16;
        armed = 0;
        clear_queue();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        push_request(REQ_DISARM, 0, '0, 0, 0);
        push_request(REQ_ARM, 0, '0, 0, 0);
        push_request(REQ_ARM, 0, '0, 0, 0);
        push_request(REQ_DISARM, 0, '0, 0, 0);
        push_receive(64);
        push_receive(0);
        push_request(REQ_ARM, 0, '0, 0, 0);
        push_message(1, 0, 0, 0);
        push_message(8, 64, 31, 0);
        push_message(1, 65, 5, 0);
        push_message(9, 8, 5, 0);
        push_message(1, 5, 31, 0);
        push_message(2, 9, 17, 0);
        push_receive(127);
        push_receive(64);
        push_receive(64);
        push_receive(64);
        push_receive(63);
        push_receive(64);
        drain();

        // fill the queue behind a long receiver hold, then pause until empty
        rx_hold = 400;
        tx_gap_max = 0;
        for (int i = 0; i < 20; i++)
            push_message(1, $urandom_range(0, 8), $urandom_range(0, 31), 0);
        for (int i = 0; i < 20; i++)
            push_receive(64);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_MAX_MSG, settings_max[ph]);
            write_reg(CFG_CAPACITY, settings_cap[ph]);
            tx_gap_max = (ph % 3 == 1) ? 0 : 19;
            rx_stall_max = (ph % 2 == 1) ? 0 : 19;
            for (int i = 0; i < 14; i++)
                push_random();
            drain();
        end
        while (n_requests < 330)
        begin
            tx_gap_max = $urandom_range(0, 1) ? 19 : 0;
            rx_stall_max = $urandom_range(0, 1) ? 19 : 0;
            for (int i = 0; i < 5; i++)
                push_random();
            drain();
        end

        $display("covered %0d requests, %0d results, %0d register writes", n_requests,
                 n_results, n_settings);
        $display("sends, receives and notify requests under random idling and a long stall");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
